// ----- rtl/action_result_dedup_table_assert.svh -----
// Assertion macros used by the checker of the dedup table.
`ifndef ACTION_RESULT_DEDUP_TABLE_ASSERT_SVH
`define ACTION_RESULT_DEDUP_TABLE_ASSERT_SVH

// Same-cycle implication, disabled while dis is true.
`define ARDT_ASSERT_SAME(lbl, dis, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("dedup table check failed");

// Next-cycle implication, disabled while dis is true.
`define ARDT_ASSERT_NEXT(lbl, dis, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("dedup table check failed");

`endif

// ----- rtl/ardt_pkg.sv -----
package ardt_pkg;

  // Default table depth.
  localparam int SLOTS_DEF = 16;

  // Stream widths.
  localparam int IN_TDATA_W  = 160;
  localparam int OUT_TDATA_W = 168;

  // Operation codes.
  localparam logic [2:0] MODE_RESERVE   = 3'd0;
  localparam logic [2:0] MODE_COMMIT    = 3'd1;
  localparam logic [2:0] MODE_GET       = 3'd2;
  localparam logic [2:0] MODE_NEXT      = 3'd3;
  localparam logic [2:0] MODE_ACK       = 3'd4;
  localparam logic [2:0] MODE_RECONCILE = 3'd5;

  // Slot states.
  localparam logic [1:0] ST_EMPTY    = 2'd0;
  localparam logic [1:0] ST_RESERVED = 2'd1;
  localparam logic [1:0] ST_TERMINAL = 2'd2;
  localparam logic [1:0] ST_ACKED    = 2'd3;

  // Result status codes.
  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_BADARG    = 3'd1;
  localparam logic [2:0] STAT_NOTREADY  = 3'd2;
  localparam logic [2:0] STAT_NOTFOUND  = 3'd3;
  localparam logic [2:0] STAT_FULL      = 3'd4;
  localparam logic [2:0] STAT_REPLAY    = 3'd5;
  localparam logic [2:0] STAT_UNCERTAIN = 3'd6;
  localparam logic [2:0] STAT_BADSTATE  = 3'd7;

  // Outcomes at or below this value are refused by commit.
  localparam logic [2:0] OUTCOME_ACCEPTED = 3'd1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_AVAILABLE      = 2'd0;
  localparam logic [1:0] CFG_FAILED_OUTCOME = 2'd1;
  localparam logic [1:0] CFG_UNCERTAIN_CODE = 2'd2;

  // One slot record.
  typedef struct packed {
    logic [63:0] dev;
    logic [63:0] act;
    logic [7:0]  cmd;
    logic [2:0]  oc;
    logic [15:0] rc;
  } entry_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic clr;
    logic scan;
    logic fin;
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic early;
    logic done;
    logic out_busy;
  } ctrl_sts_t;

endpackage

// ----- rtl/ardt_ctrl.sv -----
module ardt_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  ardt_pkg::ctrl_sts_t   sts,
  output ardt_pkg::ctrl_cmd_t   cmd
);
  import ardt_pkg::*;

  localparam logic [1:0] FSM_IDLE = 2'd0;
  localparam logic [1:0] FSM_PRE  = 2'd1;
  localparam logic [1:0] FSM_SCAN = 2'd2;
  localparam logic [1:0] FSM_FIN  = 2'd3;

  logic [1:0] state_r, state_nxt;

  // Sequencer: take an item, check arguments, scan the slots, post the result.
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_tready = (state_r == FSM_IDLE);
    unique case (state_r)
      FSM_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = FSM_PRE;
        end
      end
      FSM_PRE: begin
        if (sts.early) begin
          state_nxt = FSM_FIN;
        end else begin
          cmd.clr   = 1'b1;
          state_nxt = FSM_SCAN;
        end
      end
      FSM_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.done) state_nxt = FSM_FIN;
      end
      FSM_FIN: begin
        if (!sts.out_busy) begin
          cmd.fin   = 1'b1;
          state_nxt = FSM_IDLE;
        end
      end
      default: state_nxt = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= FSM_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

// ----- rtl/ardt_dpath.sv -----
module ardt_dpath #(
  parameter int SLOTS = ardt_pkg::SLOTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [ardt_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  ardt_pkg::ctrl_cmd_t                cmd,
  output ardt_pkg::ctrl_sts_t                sts,
  input  logic                               cfg_valid,
  input  logic [1:0]                         cfg_index,
  input  logic [15:0]                        cfg_data,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [ardt_pkg::OUT_TDATA_W-1:0]   out_tdata
);
  import ardt_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [IW:0] SLOTS_C = (IW + 1)'(SLOTS);
  localparam logic [IW:0] LAST_C  = (IW + 1)'(SLOTS - 1);

  // Unpacked input item.
  logic [2:0]  in_mode;
  entry_t      in_ent;
  assign in_mode    = in_tdata[2:0];
  assign in_ent.dev = in_tdata[66:3];
  assign in_ent.act = in_tdata[130:67];
  assign in_ent.cmd = in_tdata[138:131];
  assign in_ent.oc  = in_tdata[141:139];
  assign in_ent.rc  = in_tdata[157:142];

  // Configuration registers.
  logic        avail_r;
  logic [2:0]  fail_oc_r;
  logic [15:0] unc_code_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avail_r    <= 1'b0;
      fail_oc_r  <= 3'd2;
      unc_code_r <= 16'd259;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_AVAILABLE:      avail_r    <= cfg_data[0];
        CFG_FAILED_OUTCOME: fail_oc_r  <= cfg_data[2:0];
        CFG_UNCERTAIN_CODE: unc_code_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Argument checks that settle an item without a scan.
  logic       early;
  logic [2:0] early_code, start_code;
  always_comb begin
    early      = 1'b1;
    early_code = STAT_OK;
    priority if (in_mode > MODE_RECONCILE) begin
      early_code = STAT_BADARG;
    end else if ((in_mode == MODE_RESERVE || in_mode == MODE_ACK) &&
                 (in_ent.dev == 64'd0 || in_ent.act == 64'd0)) begin
      early_code = STAT_BADARG;
    end else if (in_mode == MODE_COMMIT && in_ent.oc <= OUTCOME_ACCEPTED) begin
      early_code = STAT_BADSTATE;
    end else if (!avail_r) begin
      early_code = STAT_NOTREADY;
    end else begin
      early = 1'b0;
    end
    if (in_mode == MODE_RESERVE)        start_code = STAT_FULL;
    else if (in_mode == MODE_RECONCILE) start_code = STAT_OK;
    else                                start_code = STAT_NOTFOUND;
  end

  // Item and result registers.
  logic [2:0]    mode_r;
  entry_t        key_r;
  logic          early_r;
  logic [2:0]    status_r;
  logic [IW-1:0] slot_r;
  logic [CW-1:0] conv_r;
  entry_t        found_r;
  logic          free_v_r;
  logic [IW-1:0] free_r;
  logic [IW-1:0] cursor_r;

  // Scan pipeline: read issue, then compare on the registered read data.
  logic [IW:0]   rd_off_r;
  logic          chk_v_r;
  logic [IW-1:0] chk_idx_r;
  logic          chk_last_r;
  entry_t        rdata_r;
  entry_t        mem [SLOTS];
  logic [1:0]    slot_st_r [SLOTS];

  logic [IW-1:0] base;
  logic [IW:0]   sum, wrapped;
  logic [IW-1:0] rd_idx;
  logic          issue;
  assign base    = (mode_r == MODE_NEXT) ? cursor_r : '0;
  assign sum     = {1'b0, base} + rd_off_r;
  assign wrapped = (sum >= SLOTS_C) ? (sum - SLOTS_C) : sum;
  assign rd_idx  = wrapped[IW-1:0];
  assign issue   = cmd.scan && (rd_off_r < SLOTS_C);

  // Compare stage.
  logic [1:0]    st;
  logic          live, term, km, hit, done;
  logic [IW:0]   next_cur;
  assign st   = slot_st_r[chk_idx_r];
  assign live = (st == ST_RESERVED) || (st == ST_TERMINAL);
  assign term = (st == ST_TERMINAL);
  assign km   = (rdata_r.dev == key_r.dev) && (rdata_r.act == key_r.act) &&
                (rdata_r.cmd == key_r.cmd);
  assign next_cur = {1'b0, chk_idx_r} + (IW + 1)'(1);

  always_comb begin
    unique case (mode_r)
      MODE_RESERVE, MODE_COMMIT: hit = live && km;
      MODE_GET, MODE_ACK:        hit = term && km;
      MODE_NEXT:                 hit = term;
      default:                   hit = 1'b0;
    endcase
  end
  assign done = chk_v_r && (hit || chk_last_r);

  // The claim of a free slot by reserve at the end of its scan.
  logic claim;
  assign claim = cmd.fin && !early_r && (mode_r == MODE_RESERVE) &&
                 (status_r == STAT_FULL) && free_v_r;

  // Single write port for records and slot states.
  logic          wr_en, st_we;
  logic [IW-1:0] wr_idx;
  entry_t        wr_data;
  logic [1:0]    st_val;
  always_comb begin
    wr_en   = 1'b0;
    st_we   = 1'b0;
    wr_idx  = chk_idx_r;
    wr_data = rdata_r;
    st_val  = ST_TERMINAL;
    if (chk_v_r) begin
      unique case (mode_r)
        MODE_COMMIT: begin
          if (hit && !term) begin
            wr_en   = 1'b1;
            st_we   = 1'b1;
            wr_data = key_r;
          end
        end
        MODE_ACK: begin
          if (hit) begin
            st_we  = 1'b1;
            st_val = ST_ACKED;
          end
        end
        MODE_RECONCILE: begin
          if (st == ST_RESERVED) begin
            wr_en      = 1'b1;
            st_we      = 1'b1;
            wr_data.oc = fail_oc_r;
            wr_data.rc = unc_code_r;
          end
        end
        default: ;
      endcase
    end
    if (claim) begin
      wr_en      = 1'b1;
      st_we      = 1'b1;
      wr_idx     = free_r;
      wr_data    = key_r;
      wr_data.oc = 3'd0;
      wr_data.rc = 16'd0;
      st_val     = ST_RESERVED;
    end
  end

  // Record memory.
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_idx] <= wr_data;
    if (issue) rdata_r <= mem[rd_idx];
  end

  // Slot states, cleared at reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) slot_st_r[i] <= ST_EMPTY;
    end else if (st_we) begin
      slot_st_r[wr_idx] <= st_val;
    end
  end

  // Scan control and the cursor.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_off_r <= '0;
      chk_v_r  <= 1'b0;
      cursor_r <= '0;
    end else begin
      if (cmd.clr) rd_off_r <= '0;
      else if (issue) rd_off_r <= rd_off_r + (IW + 1)'(1);
      chk_v_r <= issue && !done;
      if (chk_v_r && mode_r == MODE_NEXT && hit) begin
        cursor_r <= (next_cur == SLOTS_C) ? '0 : next_cur[IW-1:0];
      end
    end
  end

  // Item capture and result gathering.
  always_ff @(posedge clk) begin
    if (issue) begin
      chk_idx_r  <= rd_idx;
      chk_last_r <= (rd_off_r == LAST_C);
    end
    if (cmd.load) begin
      mode_r   <= in_mode;
      key_r    <= in_ent;
      early_r  <= early;
      status_r <= early ? early_code : start_code;
      slot_r   <= '0;
      conv_r   <= '0;
      found_r  <= '0;
    end
    if (cmd.clr) free_v_r <= 1'b0;
    if (chk_v_r) begin
      unique case (mode_r)
        MODE_RESERVE: begin
          if (hit) begin
            status_r <= term ? STAT_REPLAY : STAT_UNCERTAIN;
            slot_r   <= chk_idx_r;
          end else if (!live && !free_v_r) begin
            free_v_r <= 1'b1;
            free_r   <= chk_idx_r;
          end
        end
        MODE_COMMIT: begin
          if (hit) begin
            status_r <= term ? STAT_BADSTATE : STAT_OK;
            slot_r   <= chk_idx_r;
          end
        end
        MODE_GET, MODE_NEXT: begin
          if (hit) begin
            status_r <= STAT_OK;
            slot_r   <= chk_idx_r;
            found_r  <= rdata_r;
          end
        end
        MODE_ACK: begin
          if (hit) begin
            status_r <= STAT_OK;
            slot_r   <= chk_idx_r;
          end
        end
        MODE_RECONCILE: begin
          if (st == ST_RESERVED) conv_r <= conv_r + CW'(1);
        end
        default: ;
      endcase
    end
  end

  // Output register.
  logic          out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic [2:0]    fin_status;
  logic [IW-1:0] fin_slot;
  assign fin_status = claim ? STAT_OK : status_r;
  assign fin_slot   = claim ? free_r : slot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.fin) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.fin) begin
      out_data_r <= {1'b0, found_r.rc, found_r.oc, found_r.cmd, found_r.act,
                     found_r.dev, 5'(conv_r), 4'(fin_slot), fin_status};
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign sts.early    = early_r;
  assign sts.done     = done;
  assign sts.out_busy = out_valid_r && !out_tready;

endmodule

// ----- rtl/action_result_dedup_table.sv -----
// Items are worked one at a time. The slot scan reads one record a cycle from the
// record memory, and a match ends the scan early; argument errors and not-ready
// answers skip the scan.
// Reset (rst_n low, synchronous): all slots empty, cursor zero, registers at defaults.
module action_result_dedup_table #(
  parameter int SLOTS = ardt_pkg::SLOTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // mode[2:0], device_key[66:3], action_key[130:67], command[138:131],
  // outcome[141:139], commit_code[157:142], zero fill above
  input  logic [ardt_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // status[2:0], slot_index[6:3], converted_count[11:7], out_device_key[75:12],
  // out_action_key[139:76], out_command[147:140], out_outcome[150:148],
  // out_commit_code[166:151], zero fill above
  output logic [ardt_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [1:0]                        cfg_index,
  input  logic [15:0]                       cfg_data
);
  import ardt_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // Registers are always writable.
  assign cfg_ready = 1'b1;

  ardt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ardt_dpath #(.SLOTS(SLOTS)) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ----- rtl/ardt_checker.sv -----
`include "action_result_dedup_table_assert.svh"

module ardt_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [ardt_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import ardt_pkg::*;

  // A pending result holds until it is taken.
  `ARDT_ASSERT_NEXT(a_out_hold, !rst_n, out_tvalid && !out_tready, out_tvalid)
  // Reset leaves no result pending.
  `ARDT_ASSERT_NEXT(a_reset_empty, 1'b0, !rst_n, !out_tvalid)
  // Items are worked one at a time: the input closes right after an accept.
  `ARDT_ASSERT_NEXT(a_one_at_a_time, !rst_n, in_tvalid && in_tready, !in_tready)
  // Only a successful reconcile reports converted reservations.
  `ARDT_ASSERT_SAME(a_conv_only_ok, !rst_n,
    out_tvalid && out_tdata[2:0] != STAT_OK, out_tdata[11:7] == 5'd0)
endmodule

bind action_result_dedup_table ardt_checker u_ardt_checker (.*);

// ----- dv/action_result_dedup_table_checker.sv -----
module action_result_dedup_table_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [ardt_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                                in_tvalid,
  input  logic                                in_tready,
  input  logic [ardt_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [1:0]                          cfg_index,
  input  logic [15:0]                         cfg_data,
  output int                                  fail_count,
  output int                                  pending_count,
  output int                                  result_count
);
  import ardt_pkg::*;

  localparam int NSLOT = 16;

  typedef struct packed {
    logic [15:0] rc;
    logic [2:0]  oc;
    logic [7:0]  cmd;
    logic [63:0] act;
    logic [63:0] dev;
    logic [4:0]  conv;
    logic [3:0]  slot;
    logic [2:0]  status;
  } answer_t;

  // Table mirror and register copies.
  logic [1:0]  tbl_state [NSLOT];
  entry_t      tbl_rec [NSLOT];
  logic [3:0]  cursor;
  logic        reg_avail;
  logic [2:0]  reg_fail_oc;
  logic [15:0] reg_unc_code;

  answer_t expected_answers[$];

  function automatic logic is_live(int s);
    return tbl_state[s] == ST_RESERVED || tbl_state[s] == ST_TERMINAL;
  endfunction

  function automatic logic same_key(int s, logic [63:0] d, logic [63:0] a, logic [7:0] c);
    return tbl_rec[s].dev == d && tbl_rec[s].act == a && tbl_rec[s].cmd == c;
  endfunction

  function automatic answer_t with_record(answer_t r, int s);
    r.dev = tbl_rec[s].dev;
    r.act = tbl_rec[s].act;
    r.cmd = tbl_rec[s].cmd;
    r.oc  = tbl_rec[s].oc;
    r.rc  = tbl_rec[s].rc;
    return r;
  endfunction

  // Apply one item to the mirror and return the answer it should produce.
  function automatic answer_t predict_answer(logic [IN_TDATA_W-1:0] d);
    logic [2:0]  md;
    logic [63:0] dv, ak;
    logic [7:0]  cm;
    logic [2:0]  oc;
    logic [15:0] rc;
    answer_t     r;
    int          open_slot;
    int          s;
    logic        hit;
    md = d[2:0]; dv = d[66:3]; ak = d[130:67]; cm = d[138:131];
    oc = d[141:139]; rc = d[157:142];
    r = '0;
    hit = 1'b0;
    if (md > MODE_RECONCILE) begin
      r.status = STAT_BADARG;
    end else if ((md == MODE_RESERVE || md == MODE_ACK) && (dv == 0 || ak == 0)) begin
      r.status = STAT_BADARG;
    end else if (md == MODE_COMMIT && oc <= OUTCOME_ACCEPTED) begin
      r.status = STAT_BADSTATE;
    end else if (!reg_avail) begin
      r.status = STAT_NOTREADY;
    end else begin
      case (md)
        MODE_RESERVE: begin
          open_slot = NSLOT;
          r.status = STAT_FULL;
          for (s = 0; s < NSLOT && !hit; s++) begin
            if (is_live(s) && same_key(s, dv, ak, cm)) begin
              r.status = (tbl_state[s] == ST_TERMINAL) ? STAT_REPLAY : STAT_UNCERTAIN;
              r.slot = 4'(s);
              hit = 1'b1;
            end else if (!is_live(s) && open_slot == NSLOT) begin
              open_slot = s;
            end
          end
          if (!hit && open_slot < NSLOT) begin
            tbl_state[open_slot] = ST_RESERVED;
            tbl_rec[open_slot] = '{dev: dv, act: ak, cmd: cm, oc: 3'd0, rc: 16'd0};
            r.status = STAT_OK;
            r.slot = 4'(open_slot);
          end
        end
        MODE_COMMIT: begin
          r.status = STAT_NOTFOUND;
          for (s = 0; s < NSLOT && !hit; s++) begin
            if (is_live(s) && same_key(s, dv, ak, cm)) begin
              hit = 1'b1;
              r.slot = 4'(s);
              if (tbl_state[s] == ST_TERMINAL) begin
                r.status = STAT_BADSTATE;
              end else begin
                tbl_state[s] = ST_TERMINAL;
                tbl_rec[s].oc = oc;
                tbl_rec[s].rc = rc;
                r.status = STAT_OK;
              end
            end
          end
        end
        MODE_GET, MODE_ACK: begin
          r.status = STAT_NOTFOUND;
          for (s = 0; s < NSLOT && !hit; s++) begin
            if (tbl_state[s] == ST_TERMINAL && same_key(s, dv, ak, cm)) begin
              hit = 1'b1;
              r.status = STAT_OK;
              r.slot = 4'(s);
              if (md == MODE_GET) r = with_record(r, s);
              else tbl_state[s] = ST_ACKED;
            end
          end
        end
        MODE_NEXT: begin
          r.status = STAT_NOTFOUND;
          for (int off = 0; off < NSLOT && !hit; off++) begin
            s = (cursor + off) % NSLOT;
            if (tbl_state[s] == ST_TERMINAL) begin
              hit = 1'b1;
              r.status = STAT_OK;
              r.slot = 4'(s);
              r = with_record(r, s);
              cursor = 4'((s + 1) % NSLOT);
            end
          end
        end
        default: begin
          // Reconcile fails every open reservation.
          for (s = 0; s < NSLOT; s++) begin
            if (tbl_state[s] == ST_RESERVED) begin
              tbl_state[s] = ST_TERMINAL;
              tbl_rec[s].oc = reg_fail_oc;
              tbl_rec[s].rc = reg_unc_code;
              r.conv++;
            end
          end
          r.status = STAT_OK;
        end
      endcase
    end
    return r;
  endfunction

  task automatic compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    answer_t got, want;
    if (!rst_n) begin
      for (int s = 0; s < NSLOT; s++) begin
        tbl_state[s] = ST_EMPTY;
        tbl_rec[s] = '0;
      end
      cursor = '0;
      reg_avail = 1'b0;
      reg_fail_oc = 3'd2;
      reg_unc_code = 16'd259;
      expected_answers.delete();
      fail_count = 0;
      result_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_AVAILABLE:      reg_avail = cfg_data[0];
          CFG_FAILED_OUTCOME: reg_fail_oc = cfg_data[2:0];
          CFG_UNCERTAIN_CODE: reg_unc_code = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) expected_answers.push_back(predict_answer(in_tdata));
      // Compare each result item against the oldest expectation.
      if (out_tvalid && out_tready) begin
        got = out_tdata[166:0];
        result_count++;
        if (expected_answers.size() == 0) begin
          $error("result item with no expectation waiting");
          fail_count++;
        end else begin
          want = expected_answers.pop_front();
          compare_field("status", want.status, got.status);
          compare_field("slot_index", want.slot, got.slot);
          compare_field("converted_count", want.conv, got.conv);
          compare_field("out_device_key", want.dev, got.dev);
          compare_field("out_action_key", want.act, got.act);
          compare_field("out_command", want.cmd, got.cmd);
          compare_field("out_outcome", want.oc, got.oc);
          compare_field("out_commit_code", want.rc, got.rc);
        end
      end
    end
    pending_count = expected_answers.size();
  end

endmodule

// ----- dv/action_result_dedup_table_tb.sv -----
module action_result_dedup_table_tb;
  import ardt_pkg::*;

  logic                    clk;
  logic                    rst_n;
  logic [IN_TDATA_W-1:0]   in_tdata;
  logic                    in_tvalid;
  logic                    in_tready;
  logic [OUT_TDATA_W-1:0]  out_tdata;
  logic                    out_tvalid;
  logic                    out_tready;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [1:0]              cfg_index;
  logic [15:0]             cfg_data;
  int                      fail_count;
  int                      pending_count;
  int                      result_count;
  int                      items_sent;
  logic                    long_hold;

  // Small pools of keys so that random items hit stored records often.
  logic [63:0] dev_pool [4];
  logic [63:0] act_pool [4];
  logic [7:0]  cmd_pool [3];

  action_result_dedup_table u_dut (
    .clk, .rst_n, .in_tdata, .in_tvalid, .in_tready, .out_tdata, .out_tvalid,
    .out_tready, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  action_result_dedup_table_checker u_checker (
    .clk, .rst_n, .in_tdata, .in_tvalid, .in_tready, .out_tdata, .out_tvalid,
    .out_tready, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .fail_count, .pending_count, .result_count
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("timeout");
    $display("status: fail");
    $finish;
  end

  // Receiver stalls on its own pattern, with one long hold-off on request.
  initial begin
    int hold_cycles;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_tready <= 1'b0;
        for (hold_cycles = 0; hold_cycles < 400; hold_cycles++) @(negedge clk);
        long_hold = 1'b0;
      end
      out_tready <= (items_sent % 200 < 60) ? 1'b1 : ($urandom_range(0, 3) != 0);
    end
  end

  task automatic send_item(logic [2:0] md, logic [63:0] dv, logic [63:0] ak,
                           logic [7:0] cm, logic [2:0] oc, logic [15:0] rc);
    in_tdata  <= {2'b00, rc, oc, cm, ak, dv, md};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  // Random gap between bursts; lowers valid only when a gap is taken.
  task automatic maybe_gap();
    int n;
    if ($urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      n = $urandom_range(1, 30);
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    in_tvalid <= 1'b0;
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic random_item();
    logic [2:0]  md;
    logic [63:0] dv, ak;
    logic [7:0]  cm;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) md = MODE_RESERVE;
    else if (pick < 52) md = MODE_COMMIT;
    else if (pick < 64) md = MODE_GET;
    else if (pick < 74) md = MODE_NEXT;
    else if (pick < 88) md = MODE_ACK;
    else if (pick < 92) md = MODE_RECONCILE;
    else md = 3'($urandom_range(0, 7));
    if ($urandom_range(0, 19) == 0) begin
      dv = {$urandom, $urandom};
      ak = ($urandom_range(0, 3) == 0) ? 64'd0 : {$urandom, $urandom};
      cm = 8'($urandom);
    end else begin
      dv = dev_pool[$urandom_range(0, 3)];
      ak = act_pool[$urandom_range(0, 3)];
      cm = cmd_pool[$urandom_range(0, 2)];
    end
    send_item(md, dv, ak, cm, ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 1))
              : 3'($urandom_range(2, 7)), 16'($urandom));
  endtask

  initial begin
    int i;
    rst_n = 1'b0; in_tvalid = 1'b0; in_tdata = '0;
    cfg_valid = 1'b0; cfg_index = CFG_AVAILABLE; cfg_data = '0;
    items_sent = 0; long_hold = 1'b0;
    for (i = 0; i < 4; i++) begin
      dev_pool[i] = (i == 3) ? 64'hFFFF_FFFF_FFFF_FFFF : {$urandom, $urandom} | 64'd1;
      act_pool[i] = (i == 3) ? 64'h8000_0000_0000_0001 : {$urandom, $urandom} | 64'd1;
    end
    cmd_pool[0] = 8'h00; cmd_pool[1] = 8'hFF; cmd_pool[2] = 8'($urandom);
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: not ready, argument checks, then the table life cycle.
    send_item(MODE_GET, dev_pool[0], act_pool[0], 8'd1, 3'd0, 16'd0);
    send_item(MODE_RESERVE, 64'd0, act_pool[0], 8'd1, 3'd0, 16'd0);
    send_item(MODE_COMMIT, dev_pool[0], act_pool[0], 8'd1, 3'd1, 16'd0);
    drain();
    write_reg(CFG_AVAILABLE, 16'd1);
    send_item(MODE_RESERVE, dev_pool[0], 64'd0, 8'd1, 3'd0, 16'd0);
    send_item(MODE_ACK, 64'd0, act_pool[0], 8'd1, 3'd0, 16'd0);
    send_item(3'd6, dev_pool[0], act_pool[0], 8'd1, 3'd0, 16'd0);
    send_item(3'd7, dev_pool[0], act_pool[0], 8'd1, 3'd0, 16'd0);
    send_item(MODE_RESERVE, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
              8'hFF, 3'd7, 16'hFFFF);
    send_item(MODE_RESERVE, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
              8'hFF, 3'd0, 16'd0);
    send_item(MODE_COMMIT, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
              8'hFF, 3'd7, 16'hFFFF);
    send_item(MODE_RESERVE, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
              8'hFF, 3'd0, 16'd0);
    send_item(MODE_COMMIT, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
              8'hFF, 3'd2, 16'd0);
    send_item(MODE_COMMIT, 64'd0, 64'd0, 8'd0, 3'd2, 16'd0);
    send_item(MODE_GET, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
              8'hFF, 3'd0, 16'd0);
    send_item(MODE_GET, 64'd0, 64'd0, 8'd0, 3'd0, 16'd0);
    send_item(MODE_NEXT, 64'd0, 64'd0, 8'd0, 3'd0, 16'd0);
    send_item(MODE_ACK, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
              8'hFF, 3'd0, 16'd0);
    send_item(MODE_NEXT, 64'd0, 64'd0, 8'd0, 3'd0, 16'd0);
    // Fill the table past capacity, then fail the reservations.
    for (i = 0; i < 17; i++) send_item(MODE_RESERVE, 64'd1, 64'(i + 1), 8'd0, 3'd0, 16'd0);
    send_item(MODE_RECONCILE, 64'd0, 64'd0, 8'd0, 3'd0, 16'd0);
    send_item(MODE_RECONCILE, 64'd0, 64'd0, 8'd0, 3'd0, 16'd0);
    for (i = 0; i < 17; i++) send_item(MODE_ACK, 64'd1, 64'(i + 1), 8'd0, 3'd0, 16'd0);
    drain();

    // Random phases under several register settings.
    for (int phase = 0; phase < 6; phase++) begin
      write_reg(CFG_FAILED_OUTCOME, (phase == 0) ? 16'd0 : (phase == 1) ? 16'd7
                : 16'($urandom_range(0, 7)));
      write_reg(CFG_UNCERTAIN_CODE, (phase == 0) ? 16'd0 : (phase == 1) ? 16'hFFFF
                : 16'($urandom));
      write_reg(CFG_AVAILABLE, (phase == 4) ? 16'd0 : 16'd1);
      for (i = 0; i < 135; i++) begin
        if (phase == 2 && i == 20) long_hold = 1'b1;
        random_item();
        maybe_gap();
      end
      drain();
    end

    $display("covered %0d items and %0d results over six register settings,",
             items_sent, result_count);
    $display("with table overflow, reconcile, replay and round-robin scans.");
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- action_result_dedup_table.f -----
+incdir+rtl
rtl/ardt_pkg.sv
rtl/ardt_ctrl.sv
rtl/ardt_dpath.sv
rtl/action_result_dedup_table.sv
rtl/ardt_checker.sv
dv/action_result_dedup_table_checker.sv
dv/action_result_dedup_table_tb.sv
